/* design/stkc_pkg.sv */
// Shared types and codes for the stack calculator.
package stkc_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH      = 3'd0,
        FUNC_POP       = 3'd1,
        FUNC_PEEK_TOP  = 3'd2,
        FUNC_PEEK_BOT  = 3'd3,
        FUNC_ADD       = 3'd4,
        FUNC_SUB       = 3'd5,
        FUNC_MUL       = 3'd6,
        FUNC_DIV       = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FEW       = 3'd4,
        ST_DIV_ZERO  = 3'd5
    } status_t;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned COUNT_W = 11;

endpackage

/* design/stack_calculator.sv */
// Top level of the stack calculator: stack memory, sequencer and divider.
//
// Pulse start with func and operands while busy is low; the single result
// appears for exactly one cycle with done high and cannot be stalled.
// Full, empty, out-of-range and too-few-operand errors are found at decode,
// followed by the result. Push runs decode, memory write, result. Pop and
// peek run decode, one read from the single-port stack memory, registered
// read data, result. Add, subtract and multiply make two reads from the
// single-port stack memory, then the write-back. Divide by zero is found
// after the two operand reads. Divide makes the two operand reads, then runs
// the one-bit-per-cycle restoring divider over all 32 quotient bits, then the
// sign fix, then the write-back. Busy is high from the accepting edge until
// the result is shown, so a new transaction can be accepted at the edge that
// ends the result cycle. The stack memory needs no clearing after reset;
// entry_count is the count after the operation, modulo 2^11.
module stack_calculator #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [stkc_pkg::FUNC_W-1:0]    func,
    input  logic signed [stkc_pkg::WORD_W-1:0] push_value,
    input  logic [stkc_pkg::INDEX_W-1:0]   peek_index,
    output logic                           done,
    output logic signed [stkc_pkg::WORD_W-1:0] result_value,
    output logic [stkc_pkg::FUNC_W-1:0]    status,
    output logic [stkc_pkg::COUNT_W-1:0]   entry_count
);

    localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
    localparam int unsigned W         = stkc_pkg::WORD_W;
    localparam int unsigned ITER_W    = $clog2(W + 1);
    localparam int unsigned INDEX_W_L = stkc_pkg::INDEX_W;
    localparam int unsigned CMP_W     = ((CNT_W > INDEX_W_L) ? CNT_W : INDEX_W_L) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_RHS,
        S_LHS_REQ,
        S_LHS,
        S_DIV,
        S_DIV_FIX,
        S_WRITE,
        S_DONE
    } state_t;

    // Stack memory
    logic [W-1:0]      mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [W-1:0]      mem_wdata;
    logic [W-1:0]      mem_rdata_reg;

    state_t            state_reg;
    stkc_pkg::func_t   func_reg;
    logic [W-1:0]      push_reg;
    logic [INDEX_W_L-1:0] idx_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [W-1:0]      rhs_reg;
    logic [W-1:0]      val_reg;
    logic [2:0]        stat_reg;
    logic              done_reg;

    // Divider state
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      dvs_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              neg_reg;

    logic [W:0]        rem_shift;
    logic [W:0]        rem_trial;
    logic [W-1:0]      lhs_mag;
    logic [W-1:0]      rhs_mag;
    logic [2*W-1:0]    product;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  fill_ext;

    assign mem_we    = (state_reg == S_WRITE) &&
                       ((func_reg == stkc_pkg::FUNC_PUSH) ||
                        (stat_reg == stkc_pkg::ST_OK && func_reg[2]));
    assign mem_addr  = addr_reg;
    assign mem_wdata = (func_reg == stkc_pkg::FUNC_PUSH) ? push_reg : val_reg;

    // Single-port memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    // Divider step, operand magnitudes, product and widened compare operands
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign rem_trial = rem_shift - {1'b0, dvs_reg};
    assign lhs_mag   = mem_rdata_reg[W-1] ? (~mem_rdata_reg + 1'b1) : mem_rdata_reg;
    assign rhs_mag   = rhs_reg[W-1] ? (~rhs_reg + 1'b1) : rhs_reg;
    assign product   = mem_rdata_reg * rhs_reg;
    assign idx_ext   = CMP_W'(idx_reg);
    assign fill_ext  = CMP_W'(fill_reg);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
            stat_reg  <= stkc_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg  <= stkc_pkg::func_t'(func);
                        push_reg  <= push_value;
                        idx_reg   <= peek_index;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    val_reg  <= '0;
                    stat_reg <= stkc_pkg::ST_OK;
                    case (func_reg)
                        stkc_pkg::FUNC_PUSH:
                        begin
                            if (fill_reg >= CNT_W'(DEPTH))
                            begin
                                stat_reg  <= stkc_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                addr_reg  <= fill_reg[ADDR_W-1:0];
                                fill_reg  <= fill_reg + 1'b1;
                                state_reg <= S_WRITE;
                            end
                        end
                        stkc_pkg::FUNC_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                stat_reg  <= stkc_pkg::ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                addr_reg  <= ADDR_W'(fill_reg - 1'b1);
                                fill_reg  <= fill_reg - 1'b1;
                                state_reg <= S_READ_WAIT;
                            end
                        end
                        stkc_pkg::FUNC_PEEK_TOP, stkc_pkg::FUNC_PEEK_BOT:
                        begin
                            if (idx_ext >= fill_ext)
                            begin
                                stat_reg  <= stkc_pkg::ST_RANGE;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                if (func_reg == stkc_pkg::FUNC_PEEK_TOP)
                                    addr_reg <= ADDR_W'(fill_ext - idx_ext - 1'b1);
                                else
                                    addr_reg <= ADDR_W'(idx_ext);
                                state_reg <= S_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            if (fill_reg < CNT_W'(2))
                            begin
                                stat_reg  <= stkc_pkg::ST_FEW;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                addr_reg  <= ADDR_W'(fill_reg - 1'b1);
                                state_reg <= S_RHS;
                            end
                        end
                    endcase
                end
                S_READ_WAIT:
                begin
                    state_reg <= S_LHS;
                end
                S_RHS:
                begin
                    // read data for top arrives next cycle
                    addr_reg  <= ADDR_W'(fill_reg - CNT_W'(2));
                    state_reg <= S_LHS_REQ;
                end
                S_LHS_REQ:
                begin
                    rhs_reg   <= mem_rdata_reg;
                    state_reg <= S_LHS;
                end
                S_LHS:
                begin
                    case (func_reg)
                        stkc_pkg::FUNC_POP, stkc_pkg::FUNC_PEEK_TOP,
                        stkc_pkg::FUNC_PEEK_BOT:
                        begin
                            val_reg   <= mem_rdata_reg;
                            state_reg <= S_DONE;
                        end
                        stkc_pkg::FUNC_ADD:
                        begin
                            val_reg   <= mem_rdata_reg + rhs_reg;
                            fill_reg  <= fill_reg - 1'b1;
                            state_reg <= S_WRITE;
                        end
                        stkc_pkg::FUNC_SUB:
                        begin
                            val_reg   <= mem_rdata_reg - rhs_reg;
                            fill_reg  <= fill_reg - 1'b1;
                            state_reg <= S_WRITE;
                        end
                        stkc_pkg::FUNC_MUL:
                        begin
                            val_reg   <= product[W-1:0];
                            fill_reg  <= fill_reg - 1'b1;
                            state_reg <= S_WRITE;
                        end
                        stkc_pkg::FUNC_DIV:
                        begin
                            if (rhs_reg == '0)
                            begin
                                fill_reg  <= fill_reg - CNT_W'(2);
                                stat_reg  <= stkc_pkg::ST_DIV_ZERO;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                quo_reg   <= lhs_mag;
                                rem_reg   <= '0;
                                dvs_reg   <= rhs_mag;
                                neg_reg   <= mem_rdata_reg[W-1] ^ rhs_reg[W-1];
                                iter_reg  <= ITER_W'(W);
                                fill_reg  <= fill_reg - 1'b1;
                                state_reg <= S_DIV;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DIV:
                begin
                    // one restoring step per cycle
                    if (!rem_trial[W])
                    begin
                        rem_reg <= rem_trial[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b0};
                    end
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == ITER_W'(1))
                        state_reg <= S_DIV_FIX;
                end
                S_DIV_FIX:
                begin
                    if (neg_reg)
                        val_reg <= (rem_reg != '0) ? (~quo_reg) : (~quo_reg + 1'b1);
                    else
                        val_reg <= quo_reg;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (func_reg == stkc_pkg::FUNC_PUSH)
                        val_reg <= '0;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = val_reg;
    assign status       = stat_reg;
    assign entry_count  = stkc_pkg::COUNT_W'(fill_reg);

`ifndef SYNTH
    // Count never exceeds depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Busy is low while the result strobe is high
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // Errors other than divide by zero keep the count
    a_err_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE) ##1 (stat_reg == stkc_pkg::ST_FULL ||
            stat_reg == stkc_pkg::ST_EMPTY || stat_reg == stkc_pkg::ST_RANGE ||
            stat_reg == stkc_pkg::ST_FEW) |-> $stable(fill_reg))
        else $error("count changed on error");

    // Start while idle always begins a transaction
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start lost");
`endif

endmodule
